// File: hw/rtl/ctt_pkg.sv
// Shared types, character codes and helpers for the text tokenizer.
// No dependencies.
package ctt_pkg;

   localparam int POSITION_BITS = 24;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

   typedef logic [POSITION_BITS-1:0] pos_type;

   localparam pos_type POS_MAX = {POSITION_BITS{1'b1}};
   localparam pos_type POS_ONE = pos_type'(1);

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_COMMENT = 2'd1,
      MODE_STRING  = 2'd2,
      MODE_WORD    = 2'd3
   } mode_type;

   typedef struct packed {
      pos_type start;
      pos_type length;
      pos_type line;
      pos_type column;
   } token_type;

   // one queue entry: the tokens caused by one input byte
   typedef struct packed {
      token_type tok0;
      token_type tok1;
      logic      two;
   } record_type;

   function automatic pos_type sat_inc(input pos_type v);
      sat_inc = (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   function automatic pos_type tok_len(input pos_type offset, input pos_type start,
                                       input logic plus_one);
      pos_type diff;
      diff = offset - start;
      if (plus_one && diff != POS_MAX) begin
         diff = diff + POS_ONE;
      end
      if (diff == '0) begin
         diff = POS_ONE;
      end
      tok_len = diff;
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      is_delim = (c == CH_DOT) || (c == CH_COMMA) || (c == CH_EQ) || (c == CH_BANG) ||
                 (c == CH_AMP) || (c == CH_PIPE) || (c == CH_SEMI) ||
                 (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
                 (c == CH_RBRACE) || (c == CH_LBRACK) || (c == CH_RBRACK);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
                 (c == CH_FF) || (c == CH_CR);
   endfunction

endpackage

// File: hw/rtl/ctt_front.sv
// Front end: classifies each byte, tracks scan mode and position counters,
// and builds the token record for the byte. Depends on ctt_pkg.
module ctt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_byte,
   input  logic                end_of_input,
   output logic                push_valid,
   output ctt_pkg::record_type push_data
);
   import ctt_pkg::*;

   mode_type mode_ff, mode_in;
   pos_type  offset_ff, offset_in;
   pos_type  line_ff, line_in;
   pos_type  col_ff, col_in;
   pos_type  pstart_ff, pstart_in;
   pos_type  pline_ff, pline_in;
   pos_type  pcol_ff, pcol_in;

   token_type  toks [2];
   token_type  t;
   logic [1:0] n_cnt;
   logic       idle_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         offset_ff <= '0;
         line_ff   <= POS_ONE;
         col_ff    <= POS_ONE;
         pstart_ff <= '0;
         pline_ff  <= POS_ONE;
         pcol_ff   <= POS_ONE;
      end else if (accept) begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         pstart_ff <= pstart_in;
         pline_ff  <= pline_in;
         pcol_ff   <= pcol_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      offset_in = offset_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      pstart_in = pstart_ff;
      pline_in  = pline_ff;
      pcol_in   = pcol_ff;
      toks[0]   = '0;
      toks[1]   = '0;
      t         = '0;
      n_cnt     = 2'd0;
      idle_h    = 1'b0;

      case (mode_ff)
         MODE_COMMENT: begin
            if (char_byte == CH_NL) begin
               mode_in = MODE_IDLE;
               idle_h  = 1'b1;
            end else begin
               col_in = sat_inc(col_ff);
            end
         end
         MODE_STRING: begin
            if (char_byte == CH_QUOTE) begin
               t = '{start: pstart_ff, length: tok_len(offset_ff, pstart_ff, 1'b1),
                     line: pline_ff, column: pcol_ff};
               toks[n_cnt[0]] = t;
               n_cnt   = n_cnt + 2'd1;
               col_in  = sat_inc(col_ff);
               mode_in = MODE_IDLE;
            end else if (char_byte == CH_NL) begin
               t = '{start: pstart_ff, length: tok_len(offset_ff, pstart_ff, 1'b0),
                     line: pline_ff, column: pcol_ff};
               toks[n_cnt[0]] = t;
               n_cnt   = n_cnt + 2'd1;
               mode_in = MODE_IDLE;
               idle_h  = 1'b1;
            end else begin
               col_in = sat_inc(col_ff);
            end
         end
         MODE_WORD: begin
            if (char_byte == CH_NL || char_byte == CH_HASH || is_blank(char_byte) ||
                is_delim(char_byte)) begin
               t = '{start: pstart_ff, length: tok_len(offset_ff, pstart_ff, 1'b0),
                     line: pline_ff, column: pcol_ff};
               toks[n_cnt[0]] = t;
               n_cnt   = n_cnt + 2'd1;
               mode_in = MODE_IDLE;
               idle_h  = 1'b1;
            end else begin
               col_in = sat_inc(col_ff);
            end
         end
         default: begin
            idle_h = 1'b1;
         end
      endcase

      if (idle_h) begin
         if (char_byte == CH_HASH) begin
            mode_in = MODE_COMMENT;
            col_in  = sat_inc(col_in);
         end else if (char_byte == CH_NL) begin
            line_in = sat_inc(line_in);
            col_in  = POS_ONE;
         end else if (is_blank(char_byte)) begin
            col_in = sat_inc(col_in);
         end else if (char_byte == CH_QUOTE) begin
            pstart_in = offset_ff;
            pline_in  = line_in;
            pcol_in   = col_in;
            mode_in   = MODE_STRING;
            col_in    = sat_inc(col_in);
         end else if (is_delim(char_byte)) begin
            t = '{start: offset_ff, length: POS_ONE, line: line_in, column: col_in};
            toks[n_cnt[0]] = t;
            n_cnt  = n_cnt + 2'd1;
            col_in = sat_inc(col_in);
         end else begin
            pstart_in = offset_ff;
            pline_in  = line_in;
            pcol_in   = col_in;
            mode_in   = MODE_WORD;
            col_in    = sat_inc(col_in);
         end
      end

      if (end_of_input) begin
         if (mode_in == MODE_STRING || mode_in == MODE_WORD) begin
            t = '{start: pstart_in, length: tok_len(offset_ff, pstart_in, 1'b1),
                  line: pline_in, column: pcol_in};
            toks[n_cnt[0]] = t;
            n_cnt = n_cnt + 2'd1;
         end
         mode_in   = MODE_IDLE;
         offset_in = '0;
         line_in   = POS_ONE;
         col_in    = POS_ONE;
      end else begin
         offset_in = sat_inc(offset_ff);
      end
   end

   assign push_valid     = accept && (n_cnt != 2'd0);
   assign push_data.tok0 = toks[0];
   assign push_data.tok1 = toks[1];
   assign push_data.two  = n_cnt[1];

endmodule

// File: hw/rtl/ctt_queue.sv
// Short record queue between front and back end.
// Depends on ctt_pkg.
module ctt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  ctt_pkg::record_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output ctt_pkg::record_type head
);
   import ctt_pkg::*;

   record_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]     wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0]     rptr_ff, rptr_in;
   logic [QPTR_BITS:0]       count_ff, count_in;

   assign full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = push_valid ? wptr_ff + QPTR_BITS'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + QPTR_BITS'(1) : rptr_ff;
      count_in = count_ff + (QPTR_BITS+1)'(push_valid) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/ctt_back.sv
// Back end: sends the one or two tokens of the head record, one per beat.
// Depends on ctt_pkg.
module ctt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  ctt_pkg::record_type    head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ctt_pkg::pos_type       rsp_token_start,
   output ctt_pkg::pos_type       rsp_token_length,
   output ctt_pkg::pos_type       rsp_token_line,
   output ctt_pkg::pos_type       rsp_token_column,
   output logic                   rsp_last_of_run
);
   import ctt_pkg::*;

   logic      second_ff, second_in;
   logic      beat;
   token_type cur;

   assign rsp_valid = !empty;
   assign beat      = rsp_valid && rsp_ready;
   assign pop       = beat && (second_ff || !head.two);
   assign cur       = second_ff ? head.tok1 : head.tok0;

   assign rsp_token_start  = cur.start;
   assign rsp_token_length = cur.length;
   assign rsp_token_line   = cur.line;
   assign rsp_token_column = cur.column;
   assign rsp_last_of_run  = second_ff || !head.two;

   always_comb begin
      second_in = second_ff;
      if (beat) begin
         second_in = !pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

// File: hw/rtl/config_text_tokenizer.sv
// Top level of the configuration text tokenizer.
// Depends on ctt_pkg, ctt_front, ctt_queue and ctt_back.
//
// Takes one text byte per cycle and returns tokens (start offset, length, line,
// column) one per beat. The front end updates mode and counters in the cycle a
// byte is accepted; each byte that yields tokens leaves one record in a
// four-entry queue. The back end sends one token per beat, so a byte that
// yields two tokens (a word closed by a delimiter, or an end of input on a
// delimiter after a word) takes two output beats; the input stalls only when
// the queue is full. Tokens go out only from records held in the queue.
module config_text_tokenizer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_char_byte,
   input  logic                   req_end_of_input,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ctt_pkg::pos_type       rsp_token_start,
   output ctt_pkg::pos_type       rsp_token_length,
   output ctt_pkg::pos_type       rsp_token_line,
   output ctt_pkg::pos_type       rsp_token_column,
   output logic                   rsp_last_of_run
);
   import ctt_pkg::*;

   logic       accept;
   logic       push_valid;
   record_type push_data;
   logic       full;
   logic       empty;
   logic       pop;
   record_type head;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   ctt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .char_byte    (req_char_byte),
      .end_of_input (req_end_of_input),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   ctt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   ctt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_token_line   (rsp_token_line),
      .rsp_token_column (rsp_token_column),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
